FILE: design/csi_pkg.sv
// Shared types and constants for the cardinal spline interpolator.
// Depends on nothing; every other design file refers to it by scoped names.
package csi_pkg;

    localparam int SAMPLES_DEFAULT = 16;
    localparam int SEG_FIFO_DEPTH  = 2;

    localparam int COORD_W   = 16;
    localparam int OUT_W     = 18;
    localparam int TENSION_W = 9;
    localparam int TAN_W     = 26;
    localparam int WEIGHT_W  = 18;

    localparam logic [TENSION_W-1:0] TENSION_ONE = 9'd256;

    // One coordinate of a segment: the two end points and both tangents in Q.8.
    typedef struct packed {
        logic signed [COORD_W-1:0] a1;
        logic signed [COORD_W-1:0] a2;
        logic signed [TAN_W-1:0]   m1;
        logic signed [TAN_W-1:0]   m2;
    } coord_seg_t;

    typedef struct packed {
        coord_seg_t x;
        coord_seg_t y;
    } seg_t;

    // Write side of the segment queue.
    typedef struct packed {
        logic push;
        seg_t seg;
    } seg_push_t;

    // Read side of the segment queue.
    typedef struct packed {
        logic valid;
        seg_t seg;
    } seg_head_t;

endpackage

FILE: design/csi_if.sv
// Channel interfaces for control points in and interpolated samples out.
// Depends on csi_pkg for the field widths.
interface csi_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [csi_pkg::COORD_W-1:0] point_x;
    logic signed [csi_pkg::COORD_W-1:0] point_y;
    logic                               restart;

    modport source (output valid, point_x, point_y, restart, input ready);
    modport sink   (input valid, point_x, point_y, restart, output ready);
endinterface

interface csi_sample_if;
    logic                             valid;
    logic                             ready;
    logic signed [csi_pkg::OUT_W-1:0] out_x;
    logic signed [csi_pkg::OUT_W-1:0] out_y;
    logic                             segment_end;

    modport source (output valid, out_x, out_y, segment_end, input ready);
    modport sink   (input valid, out_x, out_y, segment_end, output ready);
endinterface

FILE: design/csi_front.sv
// Front end: takes control points, keeps the three-point window and the tension
// register, and turns each point that completes a window into a segment beat.
// Depends on csi_pkg and csi_point_if.
module csi_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 tension_wr_en,
    input  logic [csi_pkg::TENSION_W-1:0]        tension,
    csi_point_if.sink                            point,
    input  logic                                 fifo_full,
    output csi_pkg::seg_push_t                   push
);

    localparam logic [1:0] FILL_FULL = 2'd3;

    logic [csi_pkg::TENSION_W-1:0]        tension_reg;
    logic [1:0]                           fill_reg;
    logic [1:0]                           fill_next;
    logic signed [csi_pkg::COORD_W-1:0]   hist_x_reg [3];
    logic signed [csi_pkg::COORD_W-1:0]   hist_y_reg [3];

    logic                                 accept;
    logic [1:0]                           fill_eff;
    logic                                 window_full;
    logic [csi_pkg::TENSION_W-1:0]        scale;

    // Tangent in Q.8: scale times the difference of two points.
    function automatic logic signed [csi_pkg::TAN_W-1:0] tangent(
        input logic [csi_pkg::TENSION_W-1:0]      s,
        input logic signed [csi_pkg::COORD_W-1:0] hi,
        input logic signed [csi_pkg::COORD_W-1:0] lo
    );
        logic signed [csi_pkg::COORD_W:0]                      diff;
        logic signed [csi_pkg::COORD_W+csi_pkg::TENSION_W+1:0] prod;
        diff = $signed({hi[csi_pkg::COORD_W-1], hi}) - $signed({lo[csi_pkg::COORD_W-1], lo});
        prod = $signed({2'b00, s}) * $signed({diff[csi_pkg::COORD_W], diff});
        return prod[csi_pkg::TAN_W-1:0];
    endfunction

    assign point.ready = !fifo_full;
    assign accept      = point.valid && point.ready;
    assign fill_eff    = point.restart ? 2'd0 : fill_reg;
    assign window_full = (fill_eff == FILL_FULL);

    // Tension above one clamps the tangent scale to zero.
    assign scale = (tension_reg > csi_pkg::TENSION_ONE) ? '0
                 : csi_pkg::TENSION_ONE - tension_reg;

    always_comb
    begin
        push.push     = accept && window_full;
        push.seg.x.a1 = hist_x_reg[1];
        push.seg.x.a2 = hist_x_reg[2];
        push.seg.x.m1 = tangent(scale, hist_x_reg[2], hist_x_reg[0]);
        push.seg.x.m2 = tangent(scale, point.point_x, hist_x_reg[1]);
        push.seg.y.a1 = hist_y_reg[1];
        push.seg.y.a2 = hist_y_reg[2];
        push.seg.y.m1 = tangent(scale, hist_y_reg[2], hist_y_reg[0]);
        push.seg.y.m2 = tangent(scale, point.point_y, hist_y_reg[1]);
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && !window_full)
        begin
            fill_next = fill_eff + 2'd1;
        end
        else if (accept)
        begin
            fill_next = FILL_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (tension_wr_en)
            begin
                tension_reg <= tension;
            end
            fill_reg <= fill_next;
        end
    end

    // The window itself is payload; the fill level says which entries are live.
    always_ff @(posedge clk)
    begin
        if (accept && !window_full)
        begin
            hist_x_reg[fill_eff] <= point.point_x;
            hist_y_reg[fill_eff] <= point.point_y;
        end
        else if (accept)
        begin
            hist_x_reg[0] <= hist_x_reg[1];
            hist_y_reg[0] <= hist_y_reg[1];
            hist_x_reg[1] <= hist_x_reg[2];
            hist_y_reg[1] <= hist_y_reg[2];
            hist_x_reg[2] <= point.point_x;
            hist_y_reg[2] <= point.point_y;
        end
    end

endmodule

FILE: design/csi_seg_fifo.sv
// Short queue of segment beats between the front end and the sample engine.
// Depends on csi_pkg for the segment type and the queue depth.
module csi_seg_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csi_pkg::seg_push_t   push,
    output logic                 full,
    input  logic                 pop,
    output csi_pkg::seg_head_t   head
);

    localparam int DEPTH = csi_pkg::SEG_FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    csi_pkg::seg_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign do_push    = push.push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.seg   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.seg;
        end
    end

endmodule

FILE: design/csi_back.sv
// Sample engine: steps through the head segment's samples, one per cycle unless
// stalled; a product stage and a sum, round and saturate stage feed the output.
// Depends on csi_pkg and csi_sample_if.
module csi_back #(
    parameter int SAMPLES = csi_pkg::SAMPLES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  csi_pkg::seg_head_t head,
    output logic               pop,
    csi_sample_if.source       sample
);

    localparam int K_W        = $clog2(SAMPLES);
    localparam logic [K_W-1:0] K_LAST = K_W'(SAMPLES - 1);
    localparam int BASE_W     = csi_pkg::COORD_W + csi_pkg::WEIGHT_W;
    localparam int TPROD_W    = csi_pkg::TAN_W + csi_pkg::WEIGHT_W;
    localparam int ACC_W      = 48;
    localparam int FRAC_BITS  = 24;
    localparam int R_W        = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [R_W-1:0]   R_MAX = R_W'((64'sd1 <<< (csi_pkg::OUT_W - 1)) - 1);
    localparam logic signed [R_W-1:0]   R_MIN = R_W'(-(64'sd1 <<< (csi_pkg::OUT_W - 1)));

    typedef struct packed {
        logic signed [csi_pkg::WEIGHT_W-1:0] w0;
        logic signed [csi_pkg::WEIGHT_W-1:0] w1;
        logic signed [csi_pkg::WEIGHT_W-1:0] w2;
        logic signed [csi_pkg::WEIGHT_W-1:0] w3;
    } weight_t;

    typedef struct packed {
        logic signed [BASE_W-1:0]  p0;
        logic signed [BASE_W-1:0]  p1;
        logic signed [TPROD_W-1:0] p2;
        logic signed [TPROD_W-1:0] p3;
    } coord_prod_t;

    weight_t     w_tab [SAMPLES];
    weight_t     w_cur;
    logic [K_W-1:0] k_reg;
    logic [K_W-1:0] k_next;

    logic        s1_valid_reg;
    logic        s1_last_reg;
    coord_prod_t s1_x_reg;
    coord_prod_t s1_y_reg;

    logic                                out_valid_reg;
    logic                                out_end_reg;
    logic signed [csi_pkg::OUT_W-1:0]    out_x_reg;
    logic signed [csi_pkg::OUT_W-1:0]    out_y_reg;

    logic out_take;
    logic s1_take;
    logic issue;

    // Hermite basis weights in Q2.16, rounded half up, built at elaboration.
    for (genvar gk = 0; gk < SAMPLES; gk++)
    begin : g_weight
        localparam longint K    = longint'(gk);
        localparam longint N    = longint'(SAMPLES);
        localparam longint N3   = N * N * N;
        localparam longint D    = 2 * N3;
        localparam longint A1   = 2 * 65536 * (3 * K * K * N - 2 * K * K * K) + N3;
        localparam longint A2   = 2 * 65536 * (K * N * N - 2 * K * K * N + K * K * K) + N3;
        localparam longint A3   = 2 * 65536 * (K * K * K - K * K * N) + N3;
        localparam longint W1   = (A1 >= 0) ? (A1 / D) : -((-A1 + D - 1) / D);
        localparam longint W2   = (A2 >= 0) ? (A2 / D) : -((-A2 + D - 1) / D);
        localparam longint W3   = (A3 >= 0) ? (A3 / D) : -((-A3 + D - 1) / D);
        localparam longint W0   = 65536 - W1;
        assign w_tab[gk].w0 = csi_pkg::WEIGHT_W'(W0);
        assign w_tab[gk].w1 = csi_pkg::WEIGHT_W'(W1);
        assign w_tab[gk].w2 = csi_pkg::WEIGHT_W'(W2);
        assign w_tab[gk].w3 = csi_pkg::WEIGHT_W'(W3);
    end

    function automatic coord_prod_t products(
        input csi_pkg::coord_seg_t c,
        input weight_t             w
    );
        coord_prod_t p;
        p.p0 = BASE_W'(c.a1) * BASE_W'(w.w0);
        p.p1 = BASE_W'(c.a2) * BASE_W'(w.w1);
        p.p2 = TPROD_W'(c.m1) * TPROD_W'(w.w2);
        p.p3 = TPROD_W'(c.m2) * TPROD_W'(w.w3);
        return p;
    endfunction

    // Sum in Q.24, round half up, saturate to the output range.
    function automatic logic signed [csi_pkg::OUT_W-1:0] finish(input coord_prod_t p);
        logic signed [ACC_W-1:0] acc;
        logic signed [R_W-1:0]   r;
        logic signed [csi_pkg::OUT_W-1:0] res;
        acc = ((ACC_W'(p.p0) + ACC_W'(p.p1)) <<< 8) + ACC_W'(p.p2) + ACC_W'(p.p3) + HALF;
        r   = $signed(acc[ACC_W-1:FRAC_BITS]);
        if (r > R_MAX)
        begin
            res = R_MAX[csi_pkg::OUT_W-1:0];
        end
        else if (r < R_MIN)
        begin
            res = R_MIN[csi_pkg::OUT_W-1:0];
        end
        else
        begin
            res = r[csi_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    assign out_take = !out_valid_reg || sample.ready;
    assign s1_take  = !s1_valid_reg || out_take;
    assign issue    = head.valid && s1_take;
    assign pop      = issue && (k_reg == K_LAST);
    assign w_cur    = w_tab[k_reg];
    assign k_next   = !issue ? k_reg : ((k_reg == K_LAST) ? '0 : k_reg + 1'b1);

    assign sample.valid       = out_valid_reg;
    assign sample.out_x       = out_x_reg;
    assign sample.out_y       = out_y_reg;
    assign sample.segment_end = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (s1_take)
            begin
                s1_valid_reg <= issue;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_last_reg <= (k_reg == K_LAST);
            s1_x_reg    <= products(head.seg.x, w_cur);
            s1_y_reg    <= products(head.seg.y, w_cur);
        end
        if (out_take && s1_valid_reg)
        begin
            out_end_reg <= s1_last_reg;
            out_x_reg   <= finish(s1_x_reg);
            out_y_reg   <= finish(s1_y_reg);
        end
    end

endmodule

FILE: design/cardinal_spline_interpolator.sv
// Top level of the cardinal spline interpolator: front end, segment queue and
// sample engine. Depends on csi_pkg, csi_if, csi_front, csi_seg_fifo, csi_back.
//
//   Channel   Kind        Direction  Beat contents
//   point     csi_point   in         point_x, point_y, restart
//   sample    csi_sample  out        out_x, out_y, segment_end
//   tension   write port  in         tension (written when tension_wr_en is high)
//
// Each control point that completes a window produces SAMPLES sample beats, one per
// cycle while the output is taken; the product stage of the sample engine, which runs
// once per sample, paces such points in steady state. Points that only fill the window
// are taken one per cycle while the queue is not full. A completing point enters the
// queue, and its first sample then passes through the product stage register and the
// output register. Reset (rst_n low, asynchronous) empties the window, the queue and
// the pipeline and clears the tension to zero. The segment queue holds two segments, so
// the front end keeps taking points while the output is stalled until the queue fills.
module cardinal_spline_interpolator #(
    parameter int SAMPLES = csi_pkg::SAMPLES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tension_wr_en,
    input  logic [csi_pkg::TENSION_W-1:0] tension,
    csi_point_if.sink                     point,
    csi_sample_if.source                  sample
);

    csi_pkg::seg_push_t seg_push;
    csi_pkg::seg_head_t seg_head;
    logic               fifo_full;
    logic               seg_pop;

    // Window, tension register and tangent computation.
    csi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .tension_wr_en (tension_wr_en),
        .tension       (tension),
        .point         (point),
        .fifo_full     (fifo_full),
        .push          (seg_push)
    );

    // Decouples point intake from sample generation.
    csi_seg_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (seg_push),
        .full  (fifo_full),
        .pop   (seg_pop),
        .head  (seg_head)
    );

    // Steps through the samples of the head segment; pops it after the last one.
    csi_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (seg_head),
        .pop    (seg_pop),
        .sample (sample)
    );

endmodule

FILE: design/csi_checker.sv
// Port-level checks for the cardinal spline interpolator, bound to the top level.
// Depends on csi_pkg for the default sample count and on the top level's ports.
module csi_checker #(
    parameter int SAMPLES = csi_pkg::SAMPLES_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] out_x,
    input logic [17:0] out_y,
    input logic        out_end
);

    localparam int CNT_W = $clog2(SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

    logic [CNT_W-1:0] beat_cnt_reg;

    // Position of the next output beat within its segment.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            beat_cnt_reg <= (beat_cnt_reg == CNT_LAST) ? '0 : beat_cnt_reg + 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_end == (beat_cnt_reg == CNT_LAST)))
        else $error("segment end flag not on the last sample of a segment");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_x, out_y, out_end}))
        else $error("output beat changed while stalled");

endmodule

bind cardinal_spline_interpolator csi_checker #(
    .SAMPLES (SAMPLES)
) u_csi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (sample.valid),
    .out_ready (sample.ready),
    .out_x     (sample.out_x),
    .out_y     (sample.out_y),
    .out_end   (sample.segment_end)
);
